[sv/tcf_pkg.sv]
// Package for the telnet command filter: telnet byte codes, the parse state
// type and the structs passed between the filter's modules.
// No dependencies.
`timescale 1ns / 1ps
`default_nettype none

package tcf_pkg;

   // Telnet command bytes.
   localparam logic [7:0] TEL_IAC  = 8'd255;
   localparam logic [7:0] TEL_DONT = 8'd254;
   localparam logic [7:0] TEL_DO   = 8'd253;
   localparam logic [7:0] TEL_WONT = 8'd252;
   localparam logic [7:0] TEL_WILL = 8'd251;
   localparam logic [7:0] TEL_SB   = 8'd250;
   localparam logic [7:0] TEL_SE   = 8'd240;

   // Result kinds and refusal verbs.
   localparam logic KIND_TEXT    = 1'b0;
   localparam logic KIND_REFUSAL = 1'b1;
   localparam logic VERB_WONT    = 1'b0;
   localparam logic VERB_DONT    = 1'b1;

   // Parse state of the receive stream.
   typedef enum logic [2:0] {
      ST_DATA     = 3'd0,
      ST_CMD      = 3'd1,
      ST_DO_OPT   = 3'd2,
      ST_WILL_OPT = 3'd3,
      ST_SKIP_OPT = 3'd4,
      ST_SUB      = 3'd5,
      ST_SUB_IAC  = 3'd6
   } tcf_state_type;

   // One received byte held in the input register.
   typedef struct packed {
      logic       valid;
      logic [7:0] rx_byte;
   } tcf_item_type;

   // One result item.
   typedef struct packed {
      logic       kind;
      logic [7:0] text_byte;
      logic [7:0] refused_option;
      logic       refusal_verb;
   } tcf_result_type;

endpackage

`default_nettype wire

[sv/tcf_channels.sv]
// Valid/ready channel interfaces of the telnet command filter: the received
// byte channel and the result channel. No dependencies.
`timescale 1ns / 1ps
`default_nettype none

interface tcf_req_if;
   logic       valid;
   logic       ready;
   logic [7:0] rx_byte;

   modport source (output valid, output rx_byte, input ready);
   modport sink (input valid, input rx_byte, output ready);
endinterface

interface tcf_rsp_if;
   logic       valid;
   logic       ready;
   logic       kind;
   logic [7:0] text_byte;
   logic [7:0] refused_option;
   logic       refusal_verb;

   modport source (output valid, output kind, output text_byte, output refused_option,
                   output refusal_verb, input ready);
   modport sink (input valid, input kind, input text_byte, input refused_option,
                 input refusal_verb, output ready);
endinterface

`default_nettype wire

[sv/tcf_in_reg.sv]
// Input register of the telnet command filter: takes one byte per transfer
// from the request channel. Depends on tcf_pkg and tcf_req_if.
`timescale 1ns / 1ps
`default_nettype none

module tcf_in_reg (
   input  wire logic            clock,
   input  wire logic            reset,
   tcf_req_if.sink              req_ch,
   input  wire logic            advance,
   output tcf_pkg::tcf_item_type item
);
   import tcf_pkg::*;

   logic       valid_ff;
   logic       valid_in;
   logic [7:0] byte_ff;
   logic [7:0] byte_in;
   logic       take;

   // The register frees up whenever its byte moves on to the parser.
   assign req_ch.ready = !valid_ff || advance;
   assign take         = req_ch.valid && req_ch.ready;

   // Next contents of the input register.
   always_comb begin
      valid_in = valid_ff;
      byte_in  = byte_ff;
      if (take) begin
         valid_in = 1'b1;
         byte_in  = req_ch.rx_byte;
      end else if (advance) begin
         valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else begin
         valid_ff <= valid_in;
      end
   end

   always_ff @(posedge clock) begin
      byte_ff <= byte_in;
   end

   assign item = {valid_ff, byte_ff};

endmodule

`default_nettype wire

[sv/tcf_parser.sv]
// Parse state machine of the telnet command filter: decodes one byte per
// cycle while advance is high, to text, a refusal or none. Uses tcf_pkg.
`timescale 1ns / 1ps
`default_nettype none

module tcf_parser (
   input  wire logic                  clock,
   input  wire logic                  reset,
   input  wire tcf_pkg::tcf_item_type item,
   input  wire logic                  advance,
   output logic                       emit,
   output tcf_pkg::tcf_result_type    result
);
   import tcf_pkg::*;

   tcf_state_type state_ff;
   tcf_state_type state_in;
   tcf_state_type next_state;
   logic          fire;
   logic [7:0]    b;

   assign fire = item.valid && advance;
   assign b    = item.rx_byte;

   // Next parse state for the byte at hand.
   always_comb begin
      next_state = ST_DATA;
      case (state_ff)
         ST_CMD: begin
            if (b == TEL_DO) begin
               next_state = ST_DO_OPT;
            end else if (b == TEL_WILL) begin
               next_state = ST_WILL_OPT;
            end else if (b inside {TEL_DONT, TEL_WONT}) begin
               next_state = ST_SKIP_OPT;
            end else if (b == TEL_SB) begin
               next_state = ST_SUB;
            end
         end
         ST_DO_OPT, ST_WILL_OPT, ST_SKIP_OPT: begin
            next_state = ST_DATA;
         end
         ST_SUB: begin
            next_state = (b == TEL_IAC) ? ST_SUB_IAC : ST_SUB;
         end
         ST_SUB_IAC: begin
            next_state = (b == TEL_SE) ? ST_DATA : ST_SUB;
         end
         default: begin
            next_state = (b == TEL_IAC) ? ST_CMD : ST_DATA;
         end
      endcase
   end

   // Result for the byte at hand; unused fields are zero.
   always_comb begin
      emit   = 1'b0;
      result = '0;
      case (state_ff)
         ST_CMD: begin
            if (b == TEL_IAC) begin
               emit             = 1'b1;
               result.kind      = KIND_TEXT;
               result.text_byte = TEL_IAC;
            end
         end
         ST_DO_OPT: begin
            emit                  = 1'b1;
            result.kind           = KIND_REFUSAL;
            result.refused_option = b;
            result.refusal_verb   = VERB_WONT;
         end
         ST_WILL_OPT: begin
            emit                  = 1'b1;
            result.kind           = KIND_REFUSAL;
            result.refused_option = b;
            result.refusal_verb   = VERB_DONT;
         end
         ST_SKIP_OPT, ST_SUB, ST_SUB_IAC: begin
            emit = 1'b0;
         end
         default: begin
            if (b != TEL_IAC) begin
               emit             = 1'b1;
               result.kind      = KIND_TEXT;
               result.text_byte = b;
            end
         end
      endcase
   end

   // The state moves only when a byte is consumed.
   assign state_in = fire ? next_state : state_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_DATA;
      end else begin
         state_ff <= state_in;
      end
   end

   // An IAC in plain data always opens a command.
   a_iac_opens_cmd: assert property (@(posedge clock) disable iff (reset)
      fire && state_ff == ST_DATA && b == TEL_IAC |=> state_ff == ST_CMD)
      else $error("IAC in data did not enter command state");

   // Refusals come only from the option byte of DO or WILL.
   a_refusal_source: assert property (@(posedge clock) disable iff (reset)
      emit && result.kind == KIND_REFUSAL |->
         state_ff == ST_DO_OPT || state_ff == ST_WILL_OPT)
      else $error("refusal outside an option state");

   // Fields not used by the result kind are zero.
   a_unused_zero: assert property (@(posedge clock) disable iff (reset)
      emit |-> (result.kind == KIND_REFUSAL) ? (result.text_byte == 8'd0)
         : (result.refused_option == 8'd0 && result.refusal_verb == 1'b0))
      else $error("unused result field not zero");

   // Without a consumed byte the parse state holds.
   a_state_holds: assert property (@(posedge clock) disable iff (reset)
      !fire |=> $stable(state_ff))
      else $error("parse state changed without a byte");

endmodule

`default_nettype wire

[sv/tcf_rsp_reg.sv]
// Result register of the telnet command filter: holds one result until the
// response channel takes it. Depends on tcf_pkg and tcf_rsp_if.
`timescale 1ns / 1ps
`default_nettype none

module tcf_rsp_reg (
   input  wire logic                   clock,
   input  wire logic                   reset,
   input  wire logic                   item_valid,
   input  wire logic                   emit,
   input  wire tcf_pkg::tcf_result_type result,
   output logic                        advance,
   tcf_rsp_if.source                   rsp_ch
);
   import tcf_pkg::*;

   logic           valid_ff;
   logic           valid_in;
   tcf_result_type data_ff;
   tcf_result_type data_in;

   // The register loads when empty or when its result is being taken.
   assign advance = !valid_ff || rsp_ch.ready;

   always_comb begin
      valid_in = valid_ff;
      data_in  = data_ff;
      if (advance) begin
         valid_in = item_valid && emit;
         data_in  = result;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else begin
         valid_ff <= valid_in;
      end
   end

   always_ff @(posedge clock) begin
      data_ff <= data_in;
   end

   assign rsp_ch.valid          = valid_ff;
   assign rsp_ch.kind           = data_ff.kind;
   assign rsp_ch.text_byte      = data_ff.text_byte;
   assign rsp_ch.refused_option = data_ff.refused_option;
   assign rsp_ch.refusal_verb   = data_ff.refusal_verb;

endmodule

`default_nettype wire

[sv/telnet_command_filter.sv]
// Telnet command filter with option refusal.
//
// req_ch carries received telnet bytes, one per transfer. rsp_ch carries
// zero or one result per byte: a text byte for the terminal (kind 0) or a
// refusal to send back (kind 1, verb 0 = WONT, verb 1 = DONT, with the
// option code). IAC IAC gives one 0xFF text byte; DONT, WONT, other
// two-byte commands and whole subnegotiation blocks produce nothing.
// The parse state persists across bytes, so commands may be split anywhere.
//
// A taken byte is held in the input register and decoded from there; its
// result is loaded into the result register when that register is free or
// being read, and is valid from then on. One byte per cycle while rsp_ch
// does not stall. When rsp_ch stalls, the result register holds and the
// input register takes a byte only while it is empty; req_ch.ready then
// stays low until the result is taken. Reset empties both registers and
// returns the parser to plain data.
// Depends on tcf_pkg, tcf_req_if, tcf_rsp_if and the three tcf_ submodules.
`timescale 1ns / 1ps
`default_nettype none

module telnet_command_filter (
   input wire logic clock,
   input wire logic reset,
   tcf_req_if.sink  req_ch,
   tcf_rsp_if.source rsp_ch
);
   import tcf_pkg::*;

   tcf_item_type   item;
   tcf_result_type result;
   logic           emit;
   logic           advance;

   // Received byte register.
   tcf_in_reg u_in_reg (
      .clock   (clock),
      .reset   (reset),
      .req_ch  (req_ch),
      .advance (advance),
      .item    (item)
   );

   // Parse state and decode.
   tcf_parser u_parser (
      .clock   (clock),
      .reset   (reset),
      .item    (item),
      .advance (advance),
      .emit    (emit),
      .result  (result)
   );

   // Result register toward the response channel.
   tcf_rsp_reg u_rsp_reg (
      .clock      (clock),
      .reset      (reset),
      .item_valid (item.valid),
      .emit       (emit),
      .result     (result),
      .advance    (advance),
      .rsp_ch     (rsp_ch)
   );

endmodule

`default_nettype wire
